// ----- sv/imrs_pkg.sv -----
// Shared types, codes and helpers for the I2C master register sequencer.
package imrs_pkg;

   // Command codes on the request channel.
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_SHIFT = 2'd2;

   // Configuration register byte offset (index 0) and its reset value.
   localparam logic       CSR_TARGET_ADDRESS = 1'b0;
   localparam logic [6:0] TARGET_RESET       = 7'd106;

   localparam logic [7:0] PATTERN_LOW  = 8'h00;
   localparam logic [7:0] PATTERN_HIGH = 8'hFF;
   localparam logic [3:0] COUNT_BYTE   = 4'd8;
   localparam logic [3:0] COUNT_BIT    = 4'd1;
   localparam logic [3:0] COUNT_STOP   = 4'd0;

   typedef enum logic [2:0] {
      ACT_START = 3'd0,
      ACT_SEND  = 3'd1,
      ACT_ACK   = 3'd2,
      ACT_READ  = 3'd3,
      ACT_BIT   = 3'd4,
      ACT_STOP  = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_ADDR_W     = 4'd1,
      PH_ADDR_W_ACK = 4'd2,
      PH_REG_SENT   = 4'd3,
      PH_REG_ACK_W  = 4'd4,
      PH_DATA_SENT  = 4'd5,
      PH_END_ACK    = 4'd6,
      PH_STOP       = 4'd7,
      PH_REG_ACK_R  = 4'd8,
      PH_RESTART    = 4'd9,
      PH_ADDR_R     = 4'd10,
      PH_ADDR_R_ACK = 4'd11,
      PH_READ_BYTE  = 4'd12
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       is_write;
      logic       busy;
      logic [7:0] held_reg;
      logic [7:0] held_data;
      logic       ok_flag;
      logic [7:0] got_byte;
   } state_type;

   typedef struct packed {
      action_type action;
      logic [7:0] tx_byte;
      logic [3:0] bit_count;
      logic       sda_drive;
      logic       done_res;
      logic       success;
      logic [7:0] read_data;
   } result_type;

   function automatic result_type make_result(action_type act, logic [7:0] tx,
                                              logic [3:0] cnt, logic drv);
      result_type r;
      r           = '0;
      r.action    = act;
      r.tx_byte   = tx;
      r.bit_count = cnt;
      r.sda_drive = drv;
      return r;
   endfunction

   function automatic logic [7:0] addr_byte(logic [6:0] target, logic rd);
      return {target, rd};
   endfunction

endpackage

// ----- sv/imrs_req_if.sv -----
// Request channel: commands and shift-done events into the sequencer.
interface imrs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] reg_addr;
   logic [7:0] write_data;
   logic [7:0] rx_bits;

   modport source (output valid, output func, output reg_addr, output write_data,
                   output rx_bits, input ready);
   modport sink   (input valid, input func, input reg_addr, input write_data,
                   input rx_bits, output ready);
endinterface

// ----- sv/imrs_rsp_if.sv -----
// Response channel: shifter actions and transaction status out of the sequencer.
interface imrs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] tx_byte;
   logic [3:0] bit_count;
   logic       sda_drive;
   logic       done_res;
   logic       success;
   logic [7:0] read_data;

   modport source (output valid, output action, output tx_byte, output bit_count,
                   output sda_drive, output done_res, output success,
                   output read_data, input ready);
   modport sink   (input valid, input action, input tx_byte, input bit_count,
                   input sda_drive, input done_res, input success,
                   input read_data, output ready);
endinterface

// ----- sv/imrs_step.sv -----
// Transaction sequencer: next state and shifter action for one request word.
module imrs_step (
   input  imrs_pkg::state_type  state_i,
   input  logic [1:0]           func,
   input  logic [7:0]           reg_addr,
   input  logic [7:0]           write_data,
   input  logic [7:0]           rx_bits,
   input  logic [6:0]           target_address,
   output imrs_pkg::state_type  state_o,
   output logic                 emit_o,
   output imrs_pkg::result_type result_o
);

   logic nack;
   logic is_start;
   logic is_shift;

   assign nack     = rx_bits[0];
   assign is_start = ((func == imrs_pkg::FUNC_WRITE) || (func == imrs_pkg::FUNC_READ))
                     && !state_i.busy;
   assign is_shift = (func == imrs_pkg::FUNC_SHIFT) && state_i.busy;

   // Next state
   always_comb begin
      state_o = state_i;
      if (is_start) begin
         state_o.busy      = 1'b1;
         state_o.is_write  = (func == imrs_pkg::FUNC_WRITE);
         state_o.held_reg  = reg_addr;
         state_o.held_data = write_data;
         state_o.ok_flag   = 1'b0;
         state_o.got_byte  = '0;
         state_o.phase     = imrs_pkg::PH_ADDR_W;
      end else if (is_shift) begin
         unique case (state_i.phase)
            imrs_pkg::PH_ADDR_W:     state_o.phase = imrs_pkg::PH_ADDR_W_ACK;
            imrs_pkg::PH_DATA_SENT:  state_o.phase = imrs_pkg::PH_END_ACK;
            imrs_pkg::PH_ADDR_R:     state_o.phase = imrs_pkg::PH_ADDR_R_ACK;
            imrs_pkg::PH_ADDR_W_ACK: begin
               state_o.phase = nack ? imrs_pkg::PH_STOP : imrs_pkg::PH_REG_SENT;
            end
            imrs_pkg::PH_REG_SENT: begin
               state_o.phase = state_i.is_write ? imrs_pkg::PH_REG_ACK_W
                                                : imrs_pkg::PH_REG_ACK_R;
            end
            imrs_pkg::PH_REG_ACK_W: begin
               state_o.phase = nack ? imrs_pkg::PH_STOP : imrs_pkg::PH_DATA_SENT;
            end
            imrs_pkg::PH_END_ACK: begin
               if (state_i.is_write) begin
                  state_o.ok_flag = !nack;
               end
               state_o.phase = imrs_pkg::PH_STOP;
            end
            imrs_pkg::PH_STOP: begin
               state_o.phase = imrs_pkg::PH_IDLE;
               state_o.busy  = 1'b0;
            end
            imrs_pkg::PH_REG_ACK_R: begin
               state_o.phase = nack ? imrs_pkg::PH_STOP : imrs_pkg::PH_RESTART;
            end
            imrs_pkg::PH_RESTART:    state_o.phase = imrs_pkg::PH_ADDR_R;
            imrs_pkg::PH_ADDR_R_ACK: begin
               state_o.phase = nack ? imrs_pkg::PH_STOP : imrs_pkg::PH_READ_BYTE;
            end
            imrs_pkg::PH_READ_BYTE: begin
               state_o.got_byte = rx_bits;
               state_o.ok_flag  = 1'b1;
               state_o.phase    = imrs_pkg::PH_END_ACK;
            end
            default: begin
               state_o.phase = imrs_pkg::PH_IDLE;
               state_o.busy  = 1'b0;
            end
         endcase
      end
   end

   // Shifter action
   always_comb begin
      emit_o   = 1'b0;
      result_o = '0;
      if (is_start) begin
         emit_o   = 1'b1;
         result_o = imrs_pkg::make_result(imrs_pkg::ACT_START,
                       imrs_pkg::addr_byte(target_address, 1'b0),
                       imrs_pkg::COUNT_BYTE, 1'b1);
      end else if (is_shift) begin
         emit_o = 1'b1;
         unique case (state_i.phase)
            imrs_pkg::PH_ADDR_W, imrs_pkg::PH_REG_SENT, imrs_pkg::PH_DATA_SENT,
            imrs_pkg::PH_ADDR_R: begin
               result_o = imrs_pkg::make_result(imrs_pkg::ACT_ACK, imrs_pkg::PATTERN_LOW,
                                                imrs_pkg::COUNT_BIT, 1'b0);
            end
            imrs_pkg::PH_ADDR_W_ACK, imrs_pkg::PH_REG_ACK_W: begin
               if (nack) begin
                  result_o = imrs_pkg::make_result(imrs_pkg::ACT_BIT,
                                imrs_pkg::PATTERN_LOW, imrs_pkg::COUNT_BIT, 1'b1);
               end else begin
                  result_o = imrs_pkg::make_result(imrs_pkg::ACT_SEND,
                                (state_i.phase == imrs_pkg::PH_ADDR_W_ACK) ?
                                   state_i.held_reg : state_i.held_data,
                                imrs_pkg::COUNT_BYTE, 1'b1);
               end
            end
            imrs_pkg::PH_END_ACK: begin
               result_o = imrs_pkg::make_result(imrs_pkg::ACT_BIT, imrs_pkg::PATTERN_LOW,
                                                imrs_pkg::COUNT_BIT, 1'b1);
            end
            imrs_pkg::PH_STOP: begin
               result_o = imrs_pkg::make_result(imrs_pkg::ACT_STOP, imrs_pkg::PATTERN_HIGH,
                                                imrs_pkg::COUNT_STOP, 1'b0);
               result_o.done_res  = 1'b1;
               result_o.success   = state_i.ok_flag;
               result_o.read_data = state_i.got_byte;
            end
            imrs_pkg::PH_REG_ACK_R: begin
               // The released bit before the repeated start is a high level.
               result_o = imrs_pkg::make_result(imrs_pkg::ACT_BIT,
                             nack ? imrs_pkg::PATTERN_LOW : imrs_pkg::PATTERN_HIGH,
                             imrs_pkg::COUNT_BIT, 1'b1);
            end
            imrs_pkg::PH_RESTART: begin
               result_o = imrs_pkg::make_result(imrs_pkg::ACT_START,
                             imrs_pkg::addr_byte(target_address, 1'b1),
                             imrs_pkg::COUNT_BYTE, 1'b1);
            end
            imrs_pkg::PH_ADDR_R_ACK: begin
               if (nack) begin
                  result_o = imrs_pkg::make_result(imrs_pkg::ACT_BIT,
                                imrs_pkg::PATTERN_LOW, imrs_pkg::COUNT_BIT, 1'b1);
               end else begin
                  result_o = imrs_pkg::make_result(imrs_pkg::ACT_READ,
                                imrs_pkg::PATTERN_LOW, imrs_pkg::COUNT_BYTE, 1'b0);
               end
            end
            imrs_pkg::PH_READ_BYTE: begin
               // Master NACK after the single received byte.
               result_o = imrs_pkg::make_result(imrs_pkg::ACT_BIT, imrs_pkg::PATTERN_HIGH,
                                                imrs_pkg::COUNT_BIT, 1'b1);
            end
            default: begin
               emit_o = 1'b0;
            end
         endcase
      end
   end

endmodule

// ----- sv/i2c_master_register_sequencer_top.sv -----
// Top level of the I2C master register sequencer.
//
// The req channel takes start-write and start-read commands and the
// shift-done events of a bit-level I2C shifter; the rsp channel returns the
// next shifter action for each word that calls for one. A start command
// while a transaction runs, a shift-done while idle and the unused command
// code give no response word but are still consumed.
// A word accepted into the input register is decoded from there, and its
// response is loaded into the response register once that register is free
// or being emptied. One word per cycle is sustained while the receiver
// takes each response; the rate is set by the single input register and the
// single response register.
// When the receiver stalls, the response register holds its word and one
// further request word waits in the input register; req.ready drops only
// when both are full.
// The target address register is written over the csr APB port at offset 0
// and read back there; it resets to 0x6A. Synchronous reset returns the
// sequencer to idle and empties both registers.
module i2c_master_register_sequencer_top (
   input  logic         clock,
   input  logic         reset,
   imrs_req_if.sink     req,
   imrs_rsp_if.source   rsp,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic                 in_valid_ff;
   logic [1:0]           func_ff;
   logic [7:0]           reg_addr_ff;
   logic [7:0]           write_data_ff;
   logic [7:0]           rx_bits_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   imrs_pkg::result_type res_ff;
   imrs_pkg::result_type res_in;
   imrs_pkg::state_type  state_ff;
   imrs_pkg::state_type  state_in;
   logic [6:0]           target_ff;
   logic                 emit;
   logic                 advance;
   logic                 csr_write;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         func_ff       <= req.func;
         reg_addr_ff   <= req.reg_addr;
         write_data_ff <= req.write_data;
         rx_bits_ff    <= req.rx_bits;
      end
   end

   imrs_step u_step (
      .state_i        (state_ff),
      .func           (func_ff),
      .reg_addr       (reg_addr_ff),
      .write_data     (write_data_ff),
      .rx_bits        (rx_bits_ff),
      .target_address (target_ff),
      .state_o        (state_in),
      .emit_o         (emit),
      .result_o       (res_in)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.action    = res_ff.action;
   assign rsp.tx_byte   = res_ff.tx_byte;
   assign rsp.bit_count = res_ff.bit_count;
   assign rsp.sda_drive = res_ff.sda_drive;
   assign rsp.done_res  = res_ff.done_res;
   assign rsp.success   = res_ff.success;
   assign rsp.read_data = res_ff.read_data;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= imrs_pkg::TARGET_RESET;
      end else if (csr_write && (csr_paddr[2] == imrs_pkg::CSR_TARGET_ADDRESS)) begin
         target_ff <= csr_pwdata[6:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == imrs_pkg::CSR_TARGET_ADDRESS) ?
                       {25'd0, target_ff} : 32'd0;

   // Checks
   a_busy_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.busy == (state_ff.phase != imrs_pkg::PH_IDLE))
      else $error("busy flag and phase disagree");

   a_end_gives_done: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff.busy) |-> out_valid_ff && res_ff.done_res)
      else $error("transaction ended without a done word");

   a_success_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_ff.success |-> res_ff.done_res &&
      (res_ff.action == imrs_pkg::ACT_STOP))
      else $error("success reported outside the stop word");

endmodule
